### design/bdo_pkg.sv
`timescale 1ns / 1ps

package bdo_pkg;

    // Largest legal BCD byte
    localparam logic [7:0] BCD_MAX = 8'h99;

    // Calendar cycle lengths of the March-based day number
    localparam logic [17:0] DAYS_400Y = 18'd146097;
    localparam logic [10:0] DAYS_4Y   = 11'd1461;
    localparam logic [7:0]  MONTH_SPAN = 8'd153;

    // 146097 = 4 * 36524 + 1 and 1461 = 4 * 365 + 1, so (k * D) / 4 = k * (D >> 2) + k / 4
    localparam logic [15:0] DAYS_400Y_Q = 16'(DAYS_400Y >> 2);
    localparam logic [8:0]  DAYS_4Y_Q   = 9'(DAYS_4Y >> 2);

    // 153 = 5 * 30 + 3, so (153 * m + 2) / 5 = 30 * m + (3 * m + 2) / 5
    localparam logic [7:0] MONTH_SPAN_Q = 8'(MONTH_SPAN / 5);
    localparam logic [7:0] MONTH_SPAN_R = 8'(MONTH_SPAN % 5);

    // Floor reciprocals: the estimate is the quotient or one below it
    localparam int R400_SH = 32;
    localparam logic [14:0] R400 = 15'((64'd1 << R400_SH) / 64'(DAYS_400Y));
    localparam int R4Y_SH = 24;
    localparam logic [13:0] R4Y = 14'((64'd1 << R4Y_SH) / 64'(DAYS_4Y));
    localparam int RMON_SH = 16;
    localparam logic [8:0] RMON = 9'((64'd1 << RMON_SH) / 64'(MONTH_SPAN));

    // Ceiling reciprocals: exact for the narrow operands they see
    localparam int RDIV5_SH = 10;
    localparam logic [7:0] RDIV5 = 8'(((64'd1 << RDIV5_SH) + 64'd4) / 64'd5);
    localparam int RDIV10_SH = 11;
    localparam logic [7:0] RDIV10 = 8'(((64'd1 << RDIV10_SH) + 64'd9) / 64'd10);

    // Highest century of a legal result year
    localparam logic [6:0] CENT_MAX = 7'd99;

    typedef struct packed {
        logic [7:0] century;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
    } date_bcd_t;

    // Day number relative to the base, with error flag and original date
    typedef struct packed {
        logic       err;
        date_bcd_t  raw;
        logic [21:0] jd;
    } dn_t;

    // Recovered date in binary
    typedef struct packed {
        logic       err;
        date_bcd_t  raw;
        logic [6:0] cen;
        logic [6:0] yr;
        logic [3:0] mon;
        logic [4:0] day;
    } date_bin_t;

    function automatic logic [6:0] bcd_dec(input logic [7:0] b);
        logic [7:0] t;
        t = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
        return t[6:0];
    endfunction

    function automatic logic [7:0] bcd_enc(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  units;
        p     = 15'(v) * 15'(RDIV10);
        tens  = p[RDIV10_SH +: 4];
        units = v - 7'(7'(tens) * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

### design/bcd_date_day_offset_unit.sv
`timescale 1ns / 1ps
// Pipeline: the first of the ten register stages loads at the accepting edge, and
// the result is held on the output register.
// Throughput: one transaction per cycle; every stage takes a new transaction
// whenever the stage after it moves, so only a held output stalls the pipeline.
// Reset: rst_n clears every stage valid bit asynchronously; data registers hold
// no reset value and there is no clearing pass.

module bcd_date_day_offset_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  century_bcd,
    input  logic [7:0]  year_bcd,
    input  logic [7:0]  month_bcd,
    input  logic [7:0]  day_bcd,
    input  logic [15:0] day_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  century_out,
    output logic [7:0]  year_out,
    output logic [7:0]  month_out,
    output logic [7:0]  day_out,
    output logic        error
);

    bdo_pkg::date_bcd_t in_date;
    bdo_pkg::date_bcd_t out_date;
    bdo_pkg::dn_t       dn;
    bdo_pkg::date_bin_t db;
    logic               dn_valid, dn_ready;
    logic               db_valid, db_ready;

    // Pack the input bytes, century in the top byte
    assign in_date = {century_bcd, year_bcd, month_bcd, day_bcd};

    // Stages one to three: decode the BCD date, build the March-based day
    // number and apply the signed offset. A day number below one flags error.
    bdo_day_number u_day_number (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .in_date   (in_date),
        .day_count (day_count),
        .dn_valid  (dn_valid),
        .dn_ready  (dn_ready),
        .dn        (dn)
    );

    // Stages four to nine: split the day number back into century, year,
    // month and day. Each 400-year, four-year and month division is a reciprocal
    // multiply in one stage followed by a single correcting subtract in the next.
    bdo_date_recover u_date_recover (
        .clk      (clk),
        .rst_n    (rst_n),
        .dn_valid (dn_valid),
        .dn_ready (dn_ready),
        .dn       (dn),
        .db_valid (db_valid),
        .db_ready (db_ready),
        .db       (db)
    );

    // Stage ten: range-check the year, BCD-encode, and hold the transaction
    // in the output register. On error return the input date untouched.
    bdo_bcd_out u_bcd_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .db_valid  (db_valid),
        .db_ready  (db_ready),
        .db        (db),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_date  (out_date),
        .out_err   (error)
    );

    assign century_out = out_date.century;
    assign year_out    = out_date.year;
    assign month_out   = out_date.month;
    assign day_out     = out_date.day;

endmodule

### design/bdo_day_number.sv
`timescale 1ns / 1ps

module bdo_day_number (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  bdo_pkg::date_bcd_t in_date,
    input  logic [15:0]       day_count,
    output logic              dn_valid,
    input  logic              dn_ready,
    output bdo_pkg::dn_t      dn
);

    typedef struct packed {
        logic              err;
        logic              op;
        logic [15:0]       cnt;
        bdo_pkg::date_bcd_t raw;
        logic [6:0]        cen;
        logic [6:0]        yr;
        logic [6:0]        mon;
        logic [6:0]        day;
    } dec_t;

    typedef struct packed {
        logic              err;
        logic              op;
        logic [15:0]       cnt;
        bdo_pkg::date_bcd_t raw;
        logic [21:0]       tc;
        logic [15:0]       ty;
        logic [11:0]       tm;
        logic [6:0]        day;
    } mul_t;

    dec_t         s1_reg, s1_next;
    mul_t         s2_reg, s2_next;
    bdo_pkg::dn_t s3_reg, s3_next;
    logic         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic         s1_ready, s2_ready, s3_ready;

    assign s3_ready = !s3_valid_reg || dn_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Decode the BCD bytes and shift the year to start in March
    always_comb
    begin
        logic [6:0] cen_d;
        logic [6:0] yr_d;
        logic [6:0] mon_d;
        cen_d = bdo_pkg::bcd_dec(in_date.century);
        yr_d  = bdo_pkg::bcd_dec(in_date.year);
        mon_d = bdo_pkg::bcd_dec(in_date.month);
        s1_next.err = (in_date.century > bdo_pkg::BCD_MAX) ||
                      (in_date.year > bdo_pkg::BCD_MAX) ||
                      (in_date.month > bdo_pkg::BCD_MAX) ||
                      (in_date.day > bdo_pkg::BCD_MAX) ||
                      (cen_d == 7'd0 && yr_d == 7'd0);
        s1_next.op  = op;
        s1_next.cnt = day_count;
        s1_next.raw = in_date;
        s1_next.day = bdo_pkg::bcd_dec(in_date.day);
        s1_next.cen = cen_d;
        s1_next.yr  = yr_d;
        if (mon_d > 7'd2)
        begin
            s1_next.mon = mon_d - 7'd3;
        end
        else
        begin
            s1_next.mon = mon_d + 7'd9;
            if (yr_d == 7'd0)
            begin
                s1_next.yr  = 7'd99;
                s1_next.cen = cen_d - 7'd1;
            end
            else
            begin
                s1_next.yr = yr_d - 7'd1;
            end
        end
    end

    // Scale century, year and month into days
    always_comb
    begin
        logic [21:0] tc_mul;
        logic [15:0] ty_mul;
        logic [8:0]  m3;
        logic [15:0] p5;
        tc_mul = 22'(s1_reg.cen) * 22'(bdo_pkg::DAYS_400Y_Q);
        ty_mul = 16'(s1_reg.yr) * 16'(bdo_pkg::DAYS_4Y_Q);
        m3     = 9'(s1_reg.mon) * 9'(bdo_pkg::MONTH_SPAN_R) + 9'd2;
        p5     = 16'(m3) * 16'(bdo_pkg::RDIV5);
        s2_next.err = s1_reg.err;
        s2_next.op  = s1_reg.op;
        s2_next.cnt = s1_reg.cnt;
        s2_next.raw = s1_reg.raw;
        s2_next.day = s1_reg.day;
        s2_next.tc  = tc_mul + 22'(s1_reg.cen[6:2]);
        s2_next.ty  = ty_mul + 16'(s1_reg.yr[6:2]);
        s2_next.tm  = 12'(s1_reg.mon) * 12'(bdo_pkg::MONTH_SPAN_Q) +
                      12'(p5[bdo_pkg::RDIV5_SH +: 6]);
    end

    // Sum the day number and apply the offset; flag anything not above zero as an error
    always_comb
    begin
        logic [21:0] sum;
        logic [23:0] js;
        sum = s2_reg.tc + 22'(s2_reg.ty) + 22'(s2_reg.tm) + 22'(s2_reg.day);
        if (s2_reg.op)
        begin
            js = 24'(sum) - 24'(s2_reg.cnt);
        end
        else
        begin
            js = 24'(sum) + 24'(s2_reg.cnt);
        end
        s3_next.err = s2_reg.err || js[23] || (js == 24'd0);
        s3_next.raw = s2_reg.raw;
        s3_next.jd  = js[21:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_reg <= s1_next;
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
        if (s3_ready && s2_valid_reg)
            s3_reg <= s3_next;
    end

    assign dn_valid = s3_valid_reg;
    assign dn       = s3_reg;

endmodule

### design/bdo_date_recover.sv
`timescale 1ns / 1ps

module bdo_date_recover (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dn_valid,
    output logic              dn_ready,
    input  bdo_pkg::dn_t      dn,
    output logic              db_valid,
    input  logic              db_ready,
    output bdo_pkg::date_bin_t db
);

    typedef struct packed {
        logic              err;
        bdo_pkg::date_bcd_t raw;
        logic [23:0]       x;
        logic [6:0]        q_est;
    } s4_t;

    typedef struct packed {
        logic              err;
        bdo_pkg::date_bcd_t raw;
        logic [6:0]        q;
        logic [15:0]       r;
    } s5_t;

    typedef struct packed {
        logic              err;
        bdo_pkg::date_bcd_t raw;
        logic [6:0]        q;
        logic [17:0]       x2;
        logic [6:0]        j_est;
    } s6_t;

    typedef struct packed {
        logic              err;
        bdo_pkg::date_bcd_t raw;
        logic [6:0]        q;
        logic [6:0]        jy;
        logic [10:0]       x3;
    } s7_t;

    typedef struct packed {
        logic              err;
        bdo_pkg::date_bcd_t raw;
        logic [6:0]        q;
        logic [6:0]        jy;
        logic [10:0]       x3;
        logic [3:0]        m_est;
    } s8_t;

    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;
    s8_t s8_reg, s8_next;
    bdo_pkg::date_bin_t s9_reg, s9_next;

    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic s7_valid_reg, s8_valid_reg, s9_valid_reg;
    logic s4_ready, s5_ready, s6_ready, s7_ready, s8_ready, s9_ready;

    assign s9_ready = !s9_valid_reg || db_ready;
    assign s8_ready = !s8_valid_reg || s9_ready;
    assign s7_ready = !s7_valid_reg || s8_ready;
    assign s6_ready = !s6_valid_reg || s7_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign dn_ready = s4_ready;

    // Estimate the 400-year quotient of 4j - 1
    always_comb
    begin
        logic [38:0] p1;
        s4_next.err   = dn.err;
        s4_next.raw   = dn.raw;
        s4_next.x     = {dn.jd, 2'b00} - 24'd1;
        p1            = 39'(s4_next.x) * 39'(bdo_pkg::R400);
        s4_next.q_est = p1[bdo_pkg::R400_SH +: 7];
    end

    // Correct the 400-year quotient, keep the day within the cycle
    always_comb
    begin
        logic [24:0] rem;
        rem = 25'(s4_reg.x) - 25'(s4_reg.q_est) * 25'(bdo_pkg::DAYS_400Y);
        s5_next.err = s4_reg.err;
        s5_next.raw = s4_reg.raw;
        s5_next.q   = s4_reg.q_est;
        if (rem >= 25'(bdo_pkg::DAYS_400Y))
        begin
            s5_next.q = s4_reg.q_est + 7'd1;
            rem       = rem - 25'(bdo_pkg::DAYS_400Y);
        end
        s5_next.r = rem[17:2];
    end

    // Estimate the year within the century
    always_comb
    begin
        logic [31:0] p2;
        s6_next.err   = s5_reg.err;
        s6_next.raw   = s5_reg.raw;
        s6_next.q     = s5_reg.q;
        s6_next.x2    = {s5_reg.r, 2'b11};
        p2            = 32'(s6_next.x2) * 32'(bdo_pkg::R4Y);
        s6_next.j_est = p2[bdo_pkg::R4Y_SH +: 7];
    end

    // Correct the year, form the day of the March year
    always_comb
    begin
        logic [17:0] rem2;
        logic [11:0] r3w;
        s7_next.err = s6_reg.err;
        s7_next.raw = s6_reg.raw;
        s7_next.q   = s6_reg.q;
        s7_next.jy  = s6_reg.j_est;
        rem2 = s6_reg.x2 - 18'(s6_reg.j_est) * 18'(bdo_pkg::DAYS_4Y);
        if (rem2 >= 18'(bdo_pkg::DAYS_4Y))
        begin
            s7_next.jy = s6_reg.j_est + 7'd1;
            rem2       = rem2 - 18'(bdo_pkg::DAYS_4Y);
        end
        r3w        = 12'(rem2[10:0]) + 12'd4;
        s7_next.x3 = 11'(r3w[10:2]) * 11'd5 - 11'd3;
    end

    // Estimate the March-based month
    always_comb
    begin
        logic [19:0] p3;
        s8_next.err   = s7_reg.err;
        s8_next.raw   = s7_reg.raw;
        s8_next.q     = s7_reg.q;
        s8_next.jy    = s7_reg.jy;
        s8_next.x3    = s7_reg.x3;
        p3            = 20'(s7_reg.x3) * 20'(bdo_pkg::RMON);
        s8_next.m_est = p3[bdo_pkg::RMON_SH +: 4];
    end

    // Correct the month, take the day, move back to a January year
    always_comb
    begin
        logic [10:0] rem3;
        logic [3:0]  m;
        logic [7:0]  d5;
        logic [15:0] pd;
        m    = s8_reg.m_est;
        rem3 = s8_reg.x3 - 11'(s8_reg.m_est) * 11'(bdo_pkg::MONTH_SPAN);
        if (rem3 >= 11'(bdo_pkg::MONTH_SPAN))
        begin
            m    = s8_reg.m_est + 4'd1;
            rem3 = rem3 - 11'(bdo_pkg::MONTH_SPAN);
        end
        d5 = 8'(rem3) + 8'd5;
        pd = 16'(d5) * 16'(bdo_pkg::RDIV5);
        s9_next.err = s8_reg.err;
        s9_next.raw = s8_reg.raw;
        s9_next.day = pd[bdo_pkg::RDIV5_SH +: 5];
        s9_next.cen = s8_reg.q;
        s9_next.yr  = s8_reg.jy;
        if (m < 4'd10)
        begin
            s9_next.mon = m + 4'd3;
        end
        else
        begin
            s9_next.mon = m - 4'd9;
            if (s8_reg.jy == 7'd99)
            begin
                s9_next.yr  = 7'd0;
                s9_next.cen = s8_reg.q + 7'd1;
            end
            else
            begin
                s9_next.yr = s8_reg.jy + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
                s4_valid_reg <= dn_valid;
            if (s5_ready)
                s5_valid_reg <= s4_valid_reg;
            if (s6_ready)
                s6_valid_reg <= s5_valid_reg;
            if (s7_ready)
                s7_valid_reg <= s6_valid_reg;
            if (s8_ready)
                s8_valid_reg <= s7_valid_reg;
            if (s9_ready)
                s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && dn_valid)
            s4_reg <= s4_next;
        if (s5_ready && s4_valid_reg)
            s5_reg <= s5_next;
        if (s6_ready && s5_valid_reg)
            s6_reg <= s6_next;
        if (s7_ready && s6_valid_reg)
            s7_reg <= s7_next;
        if (s8_ready && s7_valid_reg)
            s8_reg <= s8_next;
        if (s9_ready && s8_valid_reg)
            s9_reg <= s9_next;
    end

    assign db_valid = s9_valid_reg;
    assign db       = s9_reg;

endmodule

### design/bdo_bcd_out.sv
`timescale 1ns / 1ps

module bdo_bcd_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              db_valid,
    output logic              db_ready,
    input  bdo_pkg::date_bin_t db,
    output logic              out_valid,
    input  logic              out_ready,
    output bdo_pkg::date_bcd_t out_date,
    output logic              out_err
);

    typedef struct packed {
        bdo_pkg::date_bcd_t date;
        logic              err;
    } res_t;

    res_t res_reg, res_next;
    logic out_valid_reg;

    assign db_ready = !out_valid_reg || out_ready;

    // Range-check the year, then encode or fall back to the input date
    always_comb
    begin
        logic bad;
        bad = db.err || (db.cen > bdo_pkg::CENT_MAX) ||
              (db.cen == 7'd0 && db.yr == 7'd0);
        res_next.err = bad;
        if (bad)
        begin
            res_next.date = db.raw;
        end
        else
        begin
            res_next.date.century = bdo_pkg::bcd_enc(db.cen);
            res_next.date.year    = bdo_pkg::bcd_enc(db.yr);
            res_next.date.month   = bdo_pkg::bcd_enc(7'(db.mon));
            res_next.date.day     = bdo_pkg::bcd_enc(7'(db.day));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (db_ready)
            out_valid_reg <= db_valid;
    end

    always_ff @(posedge clk)
    begin
        if (db_ready && db_valid)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_date  = res_reg.date;
    assign out_err   = res_reg.err;

endmodule

### design/bdo_checker.sv
`timescale 1ns / 1ps

module bdo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        op,
    input logic [7:0]  century_bcd,
    input logic [7:0]  year_bcd,
    input logic [7:0]  month_bcd,
    input logic [7:0]  day_bcd,
    input logic [15:0] day_count,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  century_out,
    input logic [7:0]  year_out,
    input logic [7:0]  month_out,
    input logic [7:0]  day_out,
    input logic        error
);

    // Hold a stalled result steady
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({century_out, year_out, month_out, day_out, error}))
        else $error("result changed while stalled");

    // A good result carries a calendar month
    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> month_out != 8'h00 &&
        (month_out <= 8'h09 || month_out == 8'h10 || month_out == 8'h11 ||
         month_out == 8'h12))
        else $error("month out of range");

    // A good result carries a day of one to thirty-one
    a_day: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> day_out != 8'h00 && day_out <= 8'h31 &&
        day_out[3:0] <= 4'd9)
        else $error("day out of range");

    // A good result carries a year of one to 9999 in clean BCD
    a_year: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> century_out[7:4] <= 4'd9 &&
        century_out[3:0] <= 4'd9 && year_out[7:4] <= 4'd9 &&
        year_out[3:0] <= 4'd9 && !(century_out == 8'h00 && year_out == 8'h00))
        else $error("year out of range");

endmodule

bind bcd_date_day_offset_unit bdo_checker u_bdo_checker (.*);
